// File: hw/rtl/salc_pkg.sv
// Package for the set-associative LRU cache lookup block.
// Holds sizing constants and register indexes; no dependencies.
`default_nettype none
package salc_pkg;
  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned AddrBits  = 31;
  localparam int unsigned CfgWidth  = 7;
  localparam logic CfgNumBlocks = 1'b0;
  localparam logic CfgWays      = 1'b1;
endpackage
`default_nettype wire

// File: hw/rtl/salc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module salc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: hw/rtl/set_assoc_lru_cache_lookup.sv
// Top level of the set-associative LRU cache lookup.
// Uses salc_pkg and salc_ram (tag and rank memories).
//
// Usage: one block address per input beat, one result beat per address
// (hit, set index, saturating hit and miss totals). Config writes
// (num_blocks index 0, ways index 1) take effect at once and invalidate
// all entries; the totals are kept. Write config only while idle.
// Per beat, with w the effective ways: the set count n/w comes from a
// restoring divider, the set number from a bit-serial remainder over the
// address (AddrBits = 31 bits), the base state forms the set base, the
// scan reads tag and rank one slot per cycle, the select state picks the
// victim, and the update pass reads then rewrites each rank. One beat is
// in flight at a time.
// Reset clears valid bits (flip-flops), totals and registers; no RAM
// sweep. A result waits in the output register while the receiver stalls;
// the next beat is taken only once it has gone.
`default_nettype none
module set_assoc_lru_cache_lookup #(
  parameter int unsigned MaxBlocks = salc_pkg::MaxBlocks,
  parameter int unsigned AddrBits  = salc_pkg::AddrBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [AddrBits-1:0]           block_address_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               hit_o,
  output logic [5:0]                         set_index_o,
  output logic [31:0]                        hit_count_o,
  output logic [31:0]                        miss_count_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [salc_pkg::CfgWidth-1:0] cfg_wdata_i
);
  localparam int unsigned IW = $clog2(MaxBlocks);
  localparam int unsigned NW = salc_pkg::CfgWidth;
  localparam int unsigned CW = (IW + 1 > NW) ? IW + 1 : NW;
  localparam int unsigned AW = AddrBits;
  localparam int unsigned TW = $clog2(AW + 1);

  localparam logic [2:0] StIdle = 3'd0, StDiv = 3'd1, StMod = 3'd2, StBase = 3'd3,
                         StScan = 3'd4, StSel = 3'd5, StUpd = 3'd6, StOut = 3'd7;

  logic [2:0]           st_q;
  logic [NW-1:0]        nb_q, ways_q;
  logic [MaxBlocks-1:0] valid_q;
  logic [31:0]          hits_q, miss_q;
  logic [AW-1:0]        addr_q, num_q;
  logic [CW-1:0]        den_q, rem_q, w_q, i_q;
  logic [TW-1:0]        cnt_q;
  logic [IW-1:0]        base_q, pk_q, slot_q, lru_q, free_q, rank_r_q, best_q;
  logic                 pv_q, ph_q, found_q, free_ok_q;

  logic [CW-1:0] n_eff, w_eff;
  logic [CW:0]   rem_sh;
  logic          div_ge;
  logic [CW-1:0] rem_nx;
  logic [AW-1:0] num_nx;
  logic [IW-1:0] k_cur;
  logic          ram_we, tag_we, set_valid;
  logic [AW-1:0] tag_rd;
  logic [IW-1:0] rank_rd, rank_wd;

  salc_ram #(.Width(AW), .Depth(MaxBlocks)) u_tag (
    .clk_i, .we_i(tag_we), .addr_i(k_cur), .wdata_i(addr_q), .rdata_o(tag_rd));
  salc_ram #(.Width(IW), .Depth(MaxBlocks)) u_rank (
    .clk_i, .we_i(ram_we), .addr_i(k_cur), .wdata_i(rank_wd), .rdata_o(rank_rd));

  // effective sizes
  always_comb begin
    n_eff = CW'(nb_q);
    if (nb_q == '0) n_eff = CW'(1);
    else if (CW'(nb_q) > CW'(MaxBlocks)) n_eff = CW'(MaxBlocks);
    w_eff = (ways_q == '0 || CW'(ways_q) > n_eff) ? n_eff : CW'(ways_q);
  end

  // one restoring step, shared by the set count and the set number
  assign rem_sh = {rem_q, num_q[AW-1]};
  assign div_ge = (rem_sh >= {1'b0, den_q});
  assign rem_nx = div_ge ? CW'(rem_sh - {1'b0, den_q}) : CW'(rem_sh);
  assign num_nx = {num_q[AW-2:0], div_ge};
  assign k_cur  = IW'(CW'(base_q) + i_q);

  // update pass: even cycle reads slot, odd cycle writes it back
  always_comb begin
    ram_we    = 1'b0;
    tag_we    = 1'b0;
    set_valid = 1'b0;
    rank_wd   = '0;
    if (st_q == StUpd && ph_q) begin
      if (k_cur == slot_q) begin
        ram_we    = 1'b1;
        tag_we    = !found_q;
        set_valid = 1'b1;
      end else if (valid_q[k_cur]) begin
        if (found_q ? (rank_rd < rank_r_q) : (CW'(rank_rd) < w_q - CW'(1))) begin
          ram_we  = 1'b1;
          rank_wd = rank_rd + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cfg_we_i) begin
      valid_q <= '0;
    end else if (set_valid) begin
      valid_q[k_cur] <= 1'b1;
    end
  end

  assign in_ready_o  = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      nb_q      <= NW'(64);
      ways_q    <= NW'(1);
      hits_q    <= '0;
      miss_q    <= '0;
      addr_q    <= '0;
      num_q     <= '0;
      den_q     <= '0;
      rem_q     <= '0;
      w_q       <= '0;
      i_q       <= '0;
      cnt_q     <= '0;
      base_q    <= '0;
      pk_q      <= '0;
      slot_q    <= '0;
      lru_q     <= '0;
      free_q    <= '0;
      rank_r_q  <= '0;
      best_q    <= '0;
      pv_q      <= 1'b0;
      ph_q      <= 1'b0;
      found_q   <= 1'b0;
      free_ok_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == salc_pkg::CfgNumBlocks) nb_q <= cfg_wdata_i;
        else ways_q <= cfg_wdata_i;
      end
      case (st_q)
        StIdle: begin
          if (in_valid_i) begin
            addr_q <= block_address_i;
            w_q    <= w_eff;
            den_q  <= w_eff;
            num_q  <= AW'(n_eff) << (AW - CW);
            rem_q  <= '0;
            cnt_q  <= '0;
            st_q   <= StDiv;
          end
        end
        StDiv: begin
          if (cnt_q == TW'(CW - 1)) begin
            den_q <= num_nx[CW-1:0];
            num_q <= addr_q;
            rem_q <= '0;
            cnt_q <= '0;
            st_q  <= StMod;
          end else begin
            num_q <= num_nx;
            rem_q <= rem_nx;
            cnt_q <= cnt_q + TW'(1);
          end
        end
        StMod: begin
          num_q <= num_nx;
          rem_q <= rem_nx;
          if (cnt_q == TW'(AW - 1)) st_q <= StBase;
          else cnt_q <= cnt_q + TW'(1);
        end
        StBase: begin
          base_q    <= IW'(rem_q * w_q);
          lru_q     <= IW'(rem_q * w_q);
          i_q       <= '0;
          pv_q      <= 1'b0;
          found_q   <= 1'b0;
          free_ok_q <= 1'b0;
          best_q    <= '0;
          st_q      <= StScan;
        end
        StScan: begin
          if (i_q != w_q) begin
            pk_q <= k_cur;
            pv_q <= 1'b1;
            i_q  <= i_q + CW'(1);
          end else begin
            pv_q <= 1'b0;
          end
          if (pv_q) begin
            if (valid_q[pk_q]) begin
              if (!found_q && tag_rd == addr_q) begin
                found_q  <= 1'b1;
                slot_q   <= pk_q;
                rank_r_q <= rank_rd;
              end
              if (rank_rd > best_q) begin
                best_q <= rank_rd;
                lru_q  <= pk_q;
              end
            end else if (!free_ok_q) begin
              free_ok_q <= 1'b1;
              free_q    <= pk_q;
            end
            if (i_q == w_q) st_q <= StSel;
          end
        end
        StSel: begin
          if (!found_q) slot_q <= free_ok_q ? free_q : lru_q;
          i_q  <= '0;
          ph_q <= 1'b0;
          st_q <= StUpd;
        end
        StUpd: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (i_q == w_q - CW'(1)) begin
              st_q <= StOut;
              if (found_q) begin
                if (hits_q != '1) hits_q <= hits_q + 32'd1;
              end else if (miss_q != '1) begin
                miss_q <= miss_q + 32'd1;
              end
            end else begin
              i_q <= i_q + CW'(1);
            end
          end
        end
        StOut: begin
          if (out_ready_i) st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign hit_o        = found_q;
  assign set_index_o  = 6'(rem_q);
  assign hit_count_o  = hits_q;
  assign miss_count_o = miss_q;
endmodule
`default_nettype wire
